// ===== hdl/kwr_pkg.sv =====
package kwr_pkg;

    // Characters with a role in word handling
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_HYPH = 8'h2d;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Longest keyword that can ever match
    localparam logic [4:0] KEY_MAX = 5'd24;

    // Keyword match counter width (counts up to the largest word buffer)
    localparam int KIDX_W = 6;

    // Register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_MID  = 2'd1,
        REG_KEY_HIGH = 2'd2,
        REG_KEY_LEN  = 2'd3
    } t_reg;

    function automatic logic is_word_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
               (c == CH_HYPH) || (c == CH_APOS);
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        if ((c >= 8'h41) && (c <= 8'h5a)) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Keyword character k out of the packed key registers, low register in the low bits
    function automatic logic [7:0] key_char(input logic [191:0] keys, input logic [4:0] k);
        if (k >= KEY_MAX) begin
            return 8'h00;
        end
        return keys[{k, 3'b000} +: 8];
    endfunction

endpackage

// ===== hdl/kwr_ram.sv =====
module kwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/keyword_word_replacer.sv =====
// Keyword word replacer. Text enters one character per request on the s_axis side. Letters,
// hyphen and apostrophe are collected into a word buffer of MAX_WORD characters (extra
// characters are dropped and the word is flagged in tuser); any other character, including
// 0 at end of text, closes the word and is echoed after it with tlast set. A closed word is
// lower-cased, stripped of hyphens and of a leading and a trailing apostrophe, and compared
// with the keyword in the APB registers; a match comes out as 2020 (keeping the outer
// apostrophes), anything else comes out as written. Word characters are written to the buffer
// as they arrive. A separator after a word of L buffered characters is accepted, then the L
// characters are compared (one buffer read per cycle through the single read port), a decision
// is taken, and the output characters follow, one per cycle while the output is taken: L + 1
// for a plain word, 5 to 7 for a replacement, echo included. A lone separator goes straight to
// its echo. The input is not ready from a separator until its echo is loaded into the output
// register; that register lets the next request in while the echo still waits.
module keyword_word_replacer
    import kwr_pkg::*;
#(
    parameter int MAX_WORD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_char
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] word_truncated
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int AW    = $clog2(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO  = LEN_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FIN,
        S_REP,
        S_WORD,
        S_ECHO
    } t_state;

    typedef enum logic [2:0] {
        R_LEAD,
        R_TWO_A,
        R_ZERO_A,
        R_TWO_B,
        R_ZERO_B,
        R_TRAIL
    } t_rep;

    // configuration registers
    logic [63:0] r_key_low, r_key_mid, r_key_high;
    logic [4:0]  r_key_len;
    logic [191:0] keys;
    logic        cfg_wr;
    t_reg        cfg_sel;

    // control state
    t_state            r_state, n_state;
    t_rep              r_rep, n_rep;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [KIDX_W-1:0] r_kidx, n_kidx;
    logic              r_ovf, n_ovf;
    logic              r_seen, n_seen;
    logic              r_pv, n_pv;
    logic              r_ok, n_ok;
    logic              r_first_apos, n_first_apos;
    logic              r_last_apos, n_last_apos;
    logic              r_trail, n_trail;
    logic              r_ovalid, n_ovalid;

    // payload
    logic [7:0] r_sep, n_sep;
    logic [7:0] r_pend, n_pend;
    logic [7:0] r_odata, n_odata;
    logic       r_olast, n_olast;
    logic       r_ouser, n_ouser;

    // working signals
    logic              in_acc;
    logic              slot_free;
    logic              ram_we;
    logic [7:0]        rd_data;
    logic [7:0]        lc;
    logic [LEN_W-1:0]  idx_inc;
    logic              pend_ok;
    logic              fin_ok;
    logic [KIDX_W-1:0] fin_kidx;
    logic              match;
    logic              load;
    logic [7:0]        ld_data;
    logic              ld_last;
    logic              ld_user;
    logic [7:0]        rep_char;

    // ---------------------------------------------------------------- config port
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = t_reg'(paddr[4:3]);
    assign pready  = 1'b1;
    assign keys    = {r_key_high, r_key_mid, r_key_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_mid  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_KEY_MID:  r_key_mid  <= pwdata;
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LEN:  r_key_len  <= pwdata[4:0];
                default:      r_key_len  <= r_key_len;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_MID:  prdata = r_key_mid;
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LEN:  prdata = {59'd0, r_key_len};
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- word buffer
    kwr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (n_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------- shared compare unit
    assign lc       = lower_case(rd_data);
    assign idx_inc  = r_idx + LEN_ONE;
    assign pend_ok  = ({1'b0, r_key_len} > r_kidx) && (r_pend == key_char(keys, r_kidx[4:0]));

    // the held character is the last one left; a trailing apostrophe drops out here
    always_comb begin
        fin_ok   = r_ok;
        fin_kidx = r_kidx;
        if (r_pv && (r_pend != CH_APOS)) begin
            fin_ok   = r_ok & pend_ok;
            fin_kidx = r_kidx + KIDX_W'(1);
        end
        match = fin_ok && (fin_kidx == {1'b0, r_key_len}) && !r_ovf && (r_key_len <= KEY_MAX);
    end

    always_comb begin
        unique case (r_rep)
            R_LEAD, R_TRAIL:   rep_char = CH_APOS;
            R_TWO_A, R_TWO_B:  rep_char = CH_TWO;
            R_ZERO_A, R_ZERO_B: rep_char = CH_ZERO;
            default:           rep_char = CH_ZERO;
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign slot_free     = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_rep        = r_rep;
        n_len        = r_len;
        n_idx        = r_idx;
        n_kidx       = r_kidx;
        n_ovf        = r_ovf;
        n_seen       = r_seen;
        n_pv         = r_pv;
        n_ok         = r_ok;
        n_first_apos = r_first_apos;
        n_last_apos  = r_last_apos;
        n_trail      = r_trail;
        n_sep        = r_sep;
        n_pend       = r_pend;
        ram_we       = 1'b0;
        load         = 1'b0;
        ld_data      = r_sep;
        ld_last      = 1'b0;
        ld_user      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_word_char(s_axis_tdata)) begin
                        if (r_len < LEN_FULL) begin
                            ram_we      = 1'b1;
                            n_len       = r_len + LEN_ONE;
                            n_last_apos = (s_axis_tdata == CH_APOS);
                            if (r_len == '0) begin
                                n_first_apos = (s_axis_tdata == CH_APOS);
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_sep   = s_axis_tdata;
                        n_idx   = '0;
                        n_kidx  = '0;
                        n_seen  = 1'b0;
                        n_pv    = 1'b0;
                        n_ok    = 1'b1;
                        n_state = (r_len == '0) ? S_ECHO : S_CMP;
                    end
                end
            end
            S_CMP: begin
                // one buffered character per cycle; hyphens vanish, a first apostrophe too
                n_idx = idx_inc;
                if (rd_data != CH_HYPH) begin
                    n_seen = 1'b1;
                    if (r_seen || (rd_data != CH_APOS)) begin
                        if (r_pv) begin
                            n_ok   = r_ok & pend_ok;
                            n_kidx = r_kidx + KIDX_W'(1);
                        end
                        n_pend = lc;
                        n_pv   = 1'b1;
                    end
                end
                if (idx_inc == r_len) begin
                    n_idx   = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_rep   = r_first_apos ? R_LEAD : R_TWO_A;
                n_trail = r_last_apos && (r_len >= LEN_TWO);
                n_state = match ? S_REP : S_WORD;
            end
            S_REP: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_data = rep_char;
                    unique case (r_rep)
                        R_LEAD:   n_rep = R_TWO_A;
                        R_TWO_A:  n_rep = R_ZERO_A;
                        R_ZERO_A: n_rep = R_TWO_B;
                        R_TWO_B:  n_rep = R_ZERO_B;
                        R_ZERO_B: begin
                            if (r_trail) begin
                                n_rep = R_TRAIL;
                            end else begin
                                n_state = S_ECHO;
                            end
                        end
                        R_TRAIL:  n_state = S_ECHO;
                        default:  n_state = S_ECHO;
                    endcase
                end
            end
            S_WORD: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_data = rd_data;
                    ld_user = r_ovf;
                    n_idx   = idx_inc;
                    if (idx_inc == r_len) begin
                        n_state = S_ECHO;
                    end
                end
            end
            S_ECHO: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_data = r_sep;
                    ld_last = 1'b1;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid & ~m_axis_tready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_ouser  = r_ouser;
        if (load) begin
            n_ovalid = 1'b1;
            n_odata  = ld_data;
            n_olast  = ld_last;
            n_ouser  = ld_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rep        <= R_TWO_A;
            r_len        <= '0;
            r_idx        <= '0;
            r_kidx       <= '0;
            r_ovf        <= 1'b0;
            r_seen       <= 1'b0;
            r_pv         <= 1'b0;
            r_ok         <= 1'b0;
            r_first_apos <= 1'b0;
            r_last_apos  <= 1'b0;
            r_trail      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_sep        <= '0;
            r_pend       <= '0;
            r_odata      <= '0;
            r_olast      <= 1'b0;
            r_ouser      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rep        <= n_rep;
            r_len        <= n_len;
            r_idx        <= n_idx;
            r_kidx       <= n_kidx;
            r_ovf        <= n_ovf;
            r_seen       <= n_seen;
            r_pv         <= n_pv;
            r_ok         <= n_ok;
            r_first_apos <= n_first_apos;
            r_last_apos  <= n_last_apos;
            r_trail      <= n_trail;
            r_ovalid     <= n_ovalid;
            r_sep        <= n_sep;
            r_pend       <= n_pend;
            r_odata      <= n_odata;
            r_olast      <= n_olast;
            r_ouser      <= n_ouser;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

endmodule

// ===== hdl/kwr_checker.sv =====
module kwr_checker
    import kwr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    logic s_acc;
    assign s_acc = s_axis_tvalid & s_axis_tready;

    // nothing pending on the output right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a separator request closes the input until its results are issued
    a_sep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && !is_word_char(s_axis_tdata) |=> !s_axis_tready)
        else $error("input still ready after a separator");

    // a word character only fills the buffer, it never starts a new result
    a_word_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && is_word_char(s_axis_tdata) |=> !$rose(m_axis_tvalid))
        else $error("result appeared after a word character");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind keyword_word_replacer kwr_checker u_kwr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/keyword_word_replacer_test.sv =====
`timescale 1ns / 1ps

import kwr_pkg::*;

// Tracks the rewritten text the block should produce for the characters it took
class text_scoreboard;
    localparam int WORD_CAP = 32;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_beat;

    logic [191:0] keyword;
    logic [4:0]   key_len;
    logic [7:0]   word_buf [WORD_CAP];
    int           word_len;
    bit           overflow;
    t_beat        expected_chars [$];

    function new();
        keyword  = '0;
        key_len  = '0;
        word_len = 0;
        overflow = 1'b0;
    endfunction

    static function bit is_word_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               c == CH_HYPH || c == CH_APOS;
    endfunction

    function void set_key_reg(input t_reg r, input logic [63:0] v);
        case (r)
            REG_KEY_LOW:  keyword[63:0]    = v;
            REG_KEY_MID:  keyword[127:64]  = v;
            REG_KEY_HIGH: keyword[191:128] = v;
            default:      key_len          = v[4:0];
        endcase
    endfunction

    function void push_beat(input logic [7:0] ch, input logic last, input logic trunc);
        t_beat b;
        b.ch    = ch;
        b.last  = last;
        b.trunc = trunc;
        expected_chars.push_back(b);
    endfunction

    function void note_char_in(input logic [7:0] c);
        logic [7:0] norm [WORD_CAP];
        logic [7:0] b;
        int         n;
        int         first;
        int         i;
        bit         hit;
        // word characters only fill the buffer
        if (is_word_byte(c)) begin
            if (word_len < WORD_CAP) begin
                word_buf[word_len] = c;
                word_len++;
            end else begin
                overflow = 1'b1;
            end
            return;
        end
        if (word_len > 0) begin
            // normalize: drop hyphens, lower-case, strip the outer apostrophes
            n = 0;
            for (i = 0; i < word_len; i++) begin
                b = word_buf[i];
                if (b != CH_HYPH) begin
                    if (b >= 8'h41 && b <= 8'h5a) begin
                        b = b + 8'd32;
                    end
                    norm[n] = b;
                    n++;
                end
            end
            first = (n > 0 && norm[0] == CH_APOS) ? 1 : 0;
            if (n > first && norm[n - 1] == CH_APOS) begin
                n--;
            end
            hit = !overflow && key_len <= KEY_MAX && (n - first) == key_len;
            if (hit) begin
                for (i = first; i < n; i++) begin
                    if (norm[i] != keyword[8 * (i - first) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            // replacement keeps the raw outer apostrophes
            if (hit) begin
                if (word_buf[0] == CH_APOS) begin
                    push_beat(CH_APOS, 1'b0, 1'b0);
                end
                push_beat(CH_TWO, 1'b0, 1'b0);
                push_beat(CH_ZERO, 1'b0, 1'b0);
                push_beat(CH_TWO, 1'b0, 1'b0);
                push_beat(CH_ZERO, 1'b0, 1'b0);
                if (word_len >= 2 && word_buf[word_len - 1] == CH_APOS) begin
                    push_beat(CH_APOS, 1'b0, 1'b0);
                end
            end else begin
                for (i = 0; i < word_len; i++) begin
                    push_beat(word_buf[i], 1'b0, overflow);
                end
            end
        end
        word_len = 0;
        overflow = 1'b0;
        // separator echo closes the run
        push_beat(c, 1'b1, 1'b0);
    endfunction

    // Empty string when the character matches the oldest expectation
    function string check_char_out(input logic [7:0] ch, input logic last, input logic trunc);
        t_beat want;
        string why;
        if (expected_chars.size() == 0) begin
            return $sformatf(" out_char %02h with nothing expected", ch);
        end
        want = expected_chars.pop_front();
        why  = "";
        if (ch !== want.ch) begin
            why = {why, $sformatf(" out_char %02h want %02h", ch, want.ch)};
        end
        if (last !== want.last) begin
            why = {why, $sformatf(" run_last %b want %b", last, want.last)};
        end
        if (trunc !== want.trunc) begin
            why = {why, $sformatf(" word_truncated %b want %b", trunc, want.trunc)};
        end
        return why;
    endfunction
endclass

module keyword_word_replacer_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 80;    // longest word flush plus margin
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    text_scoreboard sb = new();

    int         cycle_count = 0;
    int         mismatches  = 0;
    int         items_sent  = 0;
    int         gap_pct     = 0;
    int         stall_pct   = 0;
    bit         hold_req    = 1'b0;
    logic [7:0] word_q [$];

    keyword_word_replacer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string why);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at cycle %0d:%s", cycle_count, why);
        end
    endtask

    // output side: check each accepted character, stall at random or for a long hold
    initial begin
        int    hold_left;
        string why;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                why = sb.check_char_out(m_axis_tdata, m_axis_tlast, m_axis_tuser);
                if (why != "") begin
                    report_mismatch(why);
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // APB write: setup phase, access phase until pready, then idle
    task automatic apb_write(input t_reg r, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_key_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // keyword of len lower-case letters (rare inner apostrophe), random filler above
    function automatic logic [191:0] make_key(input int len);
        logic [191:0] k;
        int           i;
        for (i = 0; i < 24; i++) begin
            if (i < len) begin
                k[8 * i +: 8] = (i > 0 && i < len - 1 && $urandom_range(9) == 0) ?
                                CH_APOS : 8'h61 + 8'($urandom_range(25));
            end else begin
                k[8 * i +: 8] = 8'($urandom_range(255));
            end
        end
        return k;
    endfunction

    task automatic load_key(input logic [191:0] k, input logic [4:0] len);
        logic [63:0] v;
        v      = {$urandom, $urandom};
        v[4:0] = len;
        apb_write(REG_KEY_LOW, k[63:0]);
        apb_write(REG_KEY_MID, k[127:64]);
        apb_write(REG_KEY_HIGH, k[191:128]);
        apb_write(REG_KEY_LEN, v);
    endtask

    // one request per character; tvalid stays high between back-to-back requests
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_char_in(c);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // wait until every expected character is out
    task automatic drain_output();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        drain_output();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'h61 + 8'($urandom_range(25)) :
                                   8'h41 + 8'($urandom_range(25));
    endfunction

    // keyword spelled with random case, hyphens and outer apostrophes; spoil alters it
    task automatic build_key_word(input bit spoil);
        int         k;
        logic [7:0] ch;
        word_q.delete();
        if ($urandom_range(99) < 40) begin
            word_q.push_back(CH_APOS);
        end
        for (k = 0; k < sb.key_len && k < KEY_MAX; k++) begin
            ch = sb.keyword[8 * k +: 8];
            if ($urandom_range(99) < 15) begin
                word_q.push_back(CH_HYPH);
            end
            if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(99) < 30) begin
                ch = ch - 8'd32;
            end
            word_q.push_back(ch);
        end
        if ($urandom_range(99) < 40) begin
            word_q.push_back(CH_APOS);
        end
        if ($urandom_range(99) < 15) begin
            word_q.push_back(CH_HYPH);
        end
        if (spoil) begin
            case ($urandom_range(2))
                0: begin
                    if (word_q.size() > 0) begin
                        word_q[$urandom_range(word_q.size() - 1)] = rand_letter();
                    end
                end
                1: begin
                    if (word_q.size() > 0) begin
                        void'(word_q.pop_back());
                    end
                end
                default: begin
                    word_q.push_back(rand_letter());
                end
            endcase
        end
    endtask

    // long words may run past the buffer
    task automatic build_random_word(input bit long_word);
        int n;
        int i;
        int pick;
        word_q.delete();
        n = long_word ? $urandom_range(40, 30) : $urandom_range(10, 1);
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(9);
            word_q.push_back(pick == 0 ? CH_HYPH : pick == 1 ? CH_APOS : rand_letter());
        end
    endtask

    // hyphens and apostrophes only, or raw bytes
    task automatic build_odd_word(input bit noise);
        int n;
        int i;
        word_q.delete();
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) begin
            if (noise) begin
                word_q.push_back(8'($urandom_range(255)));
            end else begin
                word_q.push_back($urandom_range(1) ? CH_HYPH : CH_APOS);
            end
        end
    endtask

    task automatic send_word_and_separator();
        logic [7:0] sep;
        foreach (word_q[i]) begin
            send_char(word_q[i]);
        end
        if ($urandom_range(9) == 0) begin
            sep = 8'h00;
        end else begin
            do sep = 8'($urandom_range(255)); while (is_word_char(sep));
        end
        send_char(sep);
    endtask

    task automatic random_run(input int n);
        int stop_at;
        int pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                build_key_word(1'b0);
            end else if (pick < 50) begin
                build_key_word(1'b1);
            end else if (pick < 72) begin
                build_random_word(1'b0);
            end else if (pick < 80) begin
                build_random_word(1'b1);
            end else if (pick < 88) begin
                build_odd_word(1'b0);
            end else begin
                build_odd_word(1'b1);
            end
            send_word_and_separator();
        end
    endtask

    initial begin
        logic [191:0] k;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty keyword: punctuation-only words and a lone apostrophe match
        load_key(make_key(0), 5'd0);
        send_text("',");
        send_text("-'-");
        send_char(8'h00);
        send_text("'' ");
        send_char(8'hff);
        send_char(8'h00);
        random_run(20);
        settle();

        // short keyword: case, hyphens and outer apostrophes
        k = make_key(0);
        k[7:0]  = 8'h61;
        k[15:8] = 8'h62;
        load_key(k, 5'd2);
        send_text("A-b'.");
        send_text("'aB'");
        send_char(8'h00);
        send_text("ab-");
        send_char(8'h80);
        send_text("abc");
        send_char(8'h7f);
        random_run(40);
        settle();

        // sender gaps
        gap_pct   = 50;
        stall_pct = 0;
        load_key(make_key($urandom_range(8, 1)), 5'($urandom_range(8, 1)));
        load_key(make_key(4), 5'd4);
        random_run(60);
        settle();

        // longest keyword, receiver stalls and one long hold while input keeps coming
        gap_pct   = 0;
        stall_pct = 50;
        load_key(make_key(24), 5'd24);
        random_run(10);
        hold_req = 1'b1;
        random_run(50);
        settle();

        // keyword length past the limit never matches
        gap_pct   = 28;
        stall_pct = 28;
        load_key({192{1'b1}}, 5'd31);
        random_run(50);
        settle();

        // medium keyword, sender waits for the output to drain midway
        load_key(make_key(12), 5'd12);
        random_run(30);
        drain_output();
        random_run(30);
        settle();

        // one-letter keyword, no idling, zero filler
        gap_pct   = 0;
        stall_pct = 0;
        k = '0;
        k[7:0] = 8'h78;
        load_key(k, 5'd1);
        random_run(60);
        settle();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
